/* rtl/core/sfqr_pkg.sv */
// Package for the sync frame query responder: parse phases, register indexes,
// reply framing constants and the request type passed from parser to queue.
// Has no dependencies of its own.
`default_nettype none

package sfqr_pkg;

  // Parser phases. Codes 6 and 7 are unused and fall back to PH_RESET.
  typedef enum logic [2:0] {
    PH_RESET = 3'd0,
    PH_SYNC  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_BODY  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SYNC_VALUE = 2'd0,
    CFG_QUERY_ID   = 2'd1,
    CFG_FIRST_ID   = 2'd2,
    CFG_SECOND_ID  = 2'd3
  } cfg_index_t;

  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned ID_WIDTH  = 16;

  // Register reset values.
  localparam logic [7:0]          SYNC_VALUE_RESET = 8'd0;
  localparam logic [ID_WIDTH-1:0] QUERY_ID_RESET   = 16'd161;
  localparam logic [ID_WIDTH-1:0] SENSOR_ID_RESET  = 16'd0;

  // Smallest frame length that the parser accepts.
  localparam logic [15:0] MIN_LENGTH = 16'd8;

  // Reply framing: four sync bytes, length, id, presence, checksum.
  localparam int unsigned REPLY_BYTES  = 10;
  localparam logic [15:0] REPLY_LENGTH = 16'h0009;
  localparam logic [7:0]  PRESENCE     = 8'h01;

  // Byte slots of the reply frame.
  localparam logic [3:0] IDX_SYNC_LAST = 4'd3;
  localparam logic [3:0] IDX_LEN_HI    = 4'd4;
  localparam logic [3:0] IDX_LEN_LO    = 4'd5;
  localparam logic [3:0] IDX_ID_HI     = 4'd6;
  localparam logic [3:0] IDX_ID_LO     = 4'd7;
  localparam logic [3:0] IDX_PRESENCE  = 4'd8;
  localparam logic [3:0] IDX_CHECKSUM  = 4'd9;

  // Depth of the reply request queue.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One reply request from the parser.
  typedef struct packed {
    logic                valid;
    logic [ID_WIDTH-1:0] id;
  } reply_req_t;

endpackage

`default_nettype wire

/* rtl/core/sfqr_front.sv */
// Front end of the responder: accepts received bytes, runs the frame parser
// and raises one reply request per valid query. Depends on sfqr_pkg.
`default_nettype none

module sfqr_front #(
  parameter int unsigned SYNC_BYTES   = 4,
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         rx_valid,
  output logic                              rx_stall,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic                         queue_full,
  input  wire logic [7:0]                   sync_value,
  input  wire logic [sfqr_pkg::ID_WIDTH-1:0] query_packet_id,
  input  wire logic [sfqr_pkg::ID_WIDTH-1:0] first_sensor_id,
  input  wire logic [sfqr_pkg::ID_WIDTH-1:0] second_sensor_id,
  output sfqr_pkg::reply_req_t              req
);
  import sfqr_pkg::*;

  localparam logic [9:0]  POS_PID_HI  = 10'(SYNC_BYTES + 2);
  localparam logic [9:0]  POS_PID_LO  = 10'(SYNC_BYTES + 3);
  localparam logic [9:0]  POS_TID_HI  = 10'(SYNC_BYTES + 4);
  localparam logic [9:0]  POS_TID_LO  = 10'(SYNC_BYTES + 5);
  localparam logic [15:0] QUERY_MIN   = 16'(SYNC_BYTES + 6);
  localparam logic [15:0] LENGTH_LIM  = 16'(BUFFER_BYTES);
  localparam logic [2:0]  SYNC_TARGET = 3'(SYNC_BYTES);

  phase_t              phase, phase_next, eff_phase;
  logic [2:0]          sync_seen, sync_seen_next, eff_sync_seen, sync_inc;
  logic [9:0]          byte_position, byte_position_next, eff_pos;
  logic [10:0]         pos_inc;
  logic [15:0]         frame_length, frame_length_next, eff_length, len_new;
  logic [7:0]          running_xor, running_xor_next, eff_xor;
  logic [ID_WIDTH-1:0] packet_id, packet_id_next, eff_pid;
  logic [ID_WIDTH-1:0] target_id, target_id_next, eff_tid;
  logic                accept;
  logic                push;

  // A byte is taken unless the reply queue has no room.
  assign rx_stall = queue_full;
  assign accept   = rx_valid && !queue_full;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_RESET;
      sync_seen     <= '0;
      byte_position <= '0;
      frame_length  <= '0;
      running_xor   <= '0;
      packet_id     <= '0;
      target_id     <= '0;
      req.valid     <= 1'b0;
      req.id        <= '0;
    end else begin
      phase         <= phase_next;
      sync_seen     <= sync_seen_next;
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      running_xor   <= running_xor_next;
      packet_id     <= packet_id_next;
      target_id     <= target_id_next;
      req.valid     <= push;
      req.id        <= eff_tid;
    end
  end

  // The reset phase clears the frame and then behaves as the sync hunt.
  always_comb begin
    if (phase == PH_RESET) begin
      eff_phase     = PH_SYNC;
      eff_sync_seen = '0;
      eff_pos       = '0;
      eff_length    = '0;
      eff_xor       = '0;
      eff_pid       = '0;
      eff_tid       = '0;
    end else begin
      eff_phase     = phase;
      eff_sync_seen = sync_seen;
      eff_pos       = byte_position;
      eff_length    = frame_length;
      eff_xor       = running_xor;
      eff_pid       = packet_id;
      eff_tid       = target_id;
    end
  end

  assign sync_inc = eff_sync_seen + 3'd1;
  assign pos_inc  = {1'b0, eff_pos} + 11'd1;
  assign len_new  = {eff_length[7:0], rx_byte};

  // Next state of the parser for one accepted byte.
  always_comb begin
    phase_next         = phase;
    sync_seen_next     = sync_seen;
    byte_position_next = byte_position;
    frame_length_next  = frame_length;
    running_xor_next   = running_xor;
    packet_id_next     = packet_id;
    target_id_next     = target_id;
    push               = 1'b0;
    if (accept) begin
      phase_next         = eff_phase;
      sync_seen_next     = eff_sync_seen;
      byte_position_next = eff_pos;
      frame_length_next  = eff_length;
      running_xor_next   = eff_xor;
      packet_id_next     = eff_pid;
      target_id_next     = eff_tid;
      unique case (eff_phase)
        PH_SYNC: begin
          if (rx_byte == sync_value) begin
            running_xor_next   = eff_xor ^ rx_byte;
            byte_position_next = pos_inc[9:0];
            sync_seen_next     = sync_inc;
            if (sync_inc >= SYNC_TARGET) begin
              phase_next = PH_LENHI;
            end
          end else begin
            phase_next = PH_RESET;
          end
        end
        PH_LENHI: begin
          frame_length_next  = {8'd0, rx_byte};
          running_xor_next   = eff_xor ^ rx_byte;
          byte_position_next = pos_inc[9:0];
          phase_next         = PH_LENLO;
        end
        PH_LENLO: begin
          frame_length_next = len_new;
          if ({6'd0, eff_pos} < len_new) begin
            running_xor_next = eff_xor ^ rx_byte;
          end
          byte_position_next = pos_inc[9:0];
          if (len_new >= MIN_LENGTH && len_new < LENGTH_LIM) begin
            phase_next = PH_BODY;
          end else begin
            phase_next = PH_RESET;
          end
        end
        PH_BODY: begin
          if ({6'd0, eff_pos} < eff_length) begin
            running_xor_next = eff_xor ^ rx_byte;
          end
          // Capture the packet id and the target id at their fixed slots.
          if (eff_pos == POS_PID_HI) begin
            packet_id_next = {rx_byte, eff_pid[7:0]};
          end else if (eff_pos == POS_PID_LO) begin
            packet_id_next = {eff_pid[15:8], rx_byte};
          end else if (eff_pos == POS_TID_HI) begin
            target_id_next = {rx_byte, eff_tid[7:0]};
          end else if (eff_pos == POS_TID_LO) begin
            target_id_next = {eff_tid[15:8], rx_byte};
          end
          byte_position_next = pos_inc[9:0];
          if ({5'd0, pos_inc} >= eff_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next = PH_RESET;
          // The reply carries the matched id, which equals the target id.
          if (rx_byte == eff_xor && eff_pid == query_packet_id &&
              eff_length >= QUERY_MIN &&
              (eff_tid == first_sensor_id || eff_tid == second_sensor_id)) begin
            push = 1'b1;
          end
        end
        default: begin
          phase_next = PH_RESET;
        end
      endcase
    end
  end

  // A request is raised only by the checksum byte, which ends the frame.
  assert property (@(posedge clk) disable iff (rst)
    req.valid |-> (phase == PH_RESET))
    else $error("reply request without a finished frame");

  // The byte that raises a request was accepted with room in the queue.
  assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("reply request raised while the queue is full");

endmodule

`default_nettype wire

/* rtl/core/sfqr_fifo.sv */
// Small queue of reply requests between the parser and the reply sender.
// Register based, power-of-two depth. Depends on sfqr_pkg.
`default_nettype none

module sfqr_fifo #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sfqr_pkg::reply_req_t         req,
  input  wire logic                         pop,
  output logic [WIDTH-1:0]                  head,
  output logic                              empty,
  output logic                              full
);
  import sfqr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W + 1;

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign push  = req.valid;
  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= WIDTH'(req.id);
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("reply queue overflow");

  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("reply queue underflow");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("reply queue count out of range");

endmodule

`default_nettype wire

/* rtl/core/sfqr_back.sv */
// Reply sender: walks the ten bytes of a reply frame for the request at the
// head of the queue into a registered output channel. Depends on sfqr_pkg.
`default_nettype none

module sfqr_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [7:0]                   sync_value,
  input  wire logic [sfqr_pkg::ID_WIDTH-1:0] head_id,
  input  wire logic                         queue_empty,
  output logic                              pop,
  output logic                              tx_valid,
  input  wire logic                         tx_stall,
  output logic [7:0]                        tx_byte,
  output logic                              frame_end
);
  import sfqr_pkg::*;

  logic [3:0] idx;
  logic       load;
  logic       last;
  logic [7:0] byte_sel;
  logic [7:0] checksum;

  // Load a new beat when the output register is free or being drained.
  assign load = !queue_empty && (!tx_valid || !tx_stall);
  assign last = (idx == IDX_CHECKSUM);
  assign pop  = load && last;

  // The four sync bytes cancel in the XOR, so only the rest remains.
  assign checksum = REPLY_LENGTH[15:8] ^ REPLY_LENGTH[7:0] ^ head_id[15:8] ^
                    head_id[7:0] ^ PRESENCE;

  // Byte of the reply frame at the current slot.
  always_comb begin
    if (idx <= IDX_SYNC_LAST) begin
      byte_sel = sync_value;
    end else begin
      unique case (idx)
        IDX_LEN_HI:   byte_sel = REPLY_LENGTH[15:8];
        IDX_LEN_LO:   byte_sel = REPLY_LENGTH[7:0];
        IDX_ID_HI:    byte_sel = head_id[15:8];
        IDX_ID_LO:    byte_sel = head_id[7:0];
        IDX_PRESENCE: byte_sel = PRESENCE;
        IDX_CHECKSUM: byte_sel = checksum;
        default:      byte_sel = checksum;
      endcase
    end
  end

  // Output register and slot counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
      idx      <= '0;
    end else begin
      if (load) begin
        tx_valid <= 1'b1;
        idx      <= last ? 4'd0 : idx + 4'd1;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tx_byte   <= byte_sel;
      frame_end <= last;
    end
  end

  // After the checksum beat is loaded the counter is back at the first slot.
  assert property (@(posedge clk) disable iff (rst)
    (tx_valid && frame_end) |-> (idx == 4'd0))
    else $error("slot counter not restarted after the checksum beat");

endmodule

`default_nettype wire

/* rtl/core/sync_frame_query_responder.sv */
// Sync frame query responder: one received byte is taken per cycle.
// A valid query raises a reply request that passes through the request
// register, the reply queue and the single output register of the sender;
// the reply leaves one byte per cycle while tx_stall is low, ten bytes a frame.
// Input stalls only while the two-entry reply queue is full. Synchronous
// reset restarts the parser, empties the queue and loads register defaults.
`default_nettype none

module sync_frame_query_responder #(
  parameter int unsigned SYNC_BYTES   = 4,
  parameter int unsigned BUFFER_BYTES = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [sfqr_pkg::CFG_WIDTH-1:0] cfg_data,
  input  wire logic                          rx_valid,
  output logic                               rx_stall,
  input  wire logic [7:0]                    rx_byte,
  output logic                               tx_valid,
  input  wire logic                          tx_stall,
  output logic [7:0]                         tx_byte,
  output logic                               frame_end
);
  import sfqr_pkg::*;

  logic [7:0]          sync_value;
  logic [ID_WIDTH-1:0] query_packet_id;
  logic [ID_WIDTH-1:0] first_sensor_id;
  logic [ID_WIDTH-1:0] second_sensor_id;

  reply_req_t          req;
  logic [ID_WIDTH-1:0] head_id;
  logic                queue_empty;
  logic                queue_full;
  logic                pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value       <= SYNC_VALUE_RESET;
      query_packet_id  <= QUERY_ID_RESET;
      first_sensor_id  <= SENSOR_ID_RESET;
      second_sensor_id <= SENSOR_ID_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SYNC_VALUE: sync_value       <= cfg_data[7:0];
        CFG_QUERY_ID:   query_packet_id  <= cfg_data;
        CFG_FIRST_ID:   first_sensor_id  <= cfg_data;
        CFG_SECOND_ID:  second_sensor_id <= cfg_data;
        default:        sync_value       <= sync_value;
      endcase
    end
  end

  sfqr_front #(
    .SYNC_BYTES   (SYNC_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .rx_valid         (rx_valid),
    .rx_stall         (rx_stall),
    .rx_byte          (rx_byte),
    .queue_full       (queue_full),
    .sync_value       (sync_value),
    .query_packet_id  (query_packet_id),
    .first_sensor_id  (first_sensor_id),
    .second_sensor_id (second_sensor_id),
    .req              (req)
  );

  sfqr_fifo #(
    .WIDTH (ID_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .pop   (pop),
    .head  (head_id),
    .empty (queue_empty),
    .full  (queue_full)
  );

  sfqr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .sync_value  (sync_value),
    .head_id     (head_id),
    .queue_empty (queue_empty),
    .pop         (pop),
    .tx_valid    (tx_valid),
    .tx_stall    (tx_stall),
    .tx_byte     (tx_byte),
    .frame_end   (frame_end)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for sync_frame_query_responder: byte frames go in on the
// rx channel, and predicted reply beats are compared with the tx channel.
// Depends on sfqr_pkg and the responder RTL only.
`default_nettype none

module tb;
  import sfqr_pkg::*;

  localparam int unsigned SYNC_LEN = 4;
  localparam int unsigned BUF_LEN  = 512;

  // One reply beat as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data  = 16'd0;
  logic        rx_valid  = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte   = 8'd0;
  logic        tx_valid;
  logic        tx_stall  = 1'b0;
  logic [7:0]  tx_byte;
  logic        frame_end;

  // Register copies kept by the frame predictor.
  logic [7:0]  cfg_sync   = SYNC_VALUE_RESET;
  logic [15:0] cfg_query  = QUERY_ID_RESET;
  logic [15:0] cfg_first  = SENSOR_ID_RESET;
  logic [15:0] cfg_second = SENSOR_ID_RESET;

  // Parser state of the frame predictor.
  phase_t      parse_ph       = PH_RESET;
  logic [2:0]  syncs_matched  = 3'd0;
  logic [9:0]  frame_pos      = 10'd0;
  logic [15:0] frame_len      = 16'd0;
  logic [7:0]  frame_xor      = 8'd0;
  logic [15:0] packet_id_seen = 16'd0;
  logic [15:0] target_seen    = 16'd0;

  logic [7:0]  rx_pending[$];
  reply_beat_t reply_bytes_due[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned rx_mode      = 0;
  int unsigned tx_mode      = 0;
  int unsigned rx_wait      = 0;
  int unsigned tx_wait      = 0;
  logic        hold_kick    = 1'b0;
  int unsigned hold_left    = 0;

  sync_frame_query_responder #(
    .SYNC_BYTES  (SYNC_LEN),
    .BUFFER_BYTES(BUF_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .tx_valid (tx_valid),
    .tx_stall (tx_stall),
    .tx_byte  (tx_byte),
    .frame_end(frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("tb failed");
    $finish;
  end

  // Idle gap before a beat, by mode: none, a random gap, or an occasional gap.
  function automatic int unsigned draw_gap(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 19);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
    endcase
  endfunction

  // Mostly random register values, with both extremes now and then.
  function automatic logic [15:0] pick_value(input logic [15:0] top);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return top;
    return 16'($urandom_range(0, 65535)) & top;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    $display("mismatch at %0t: %s, got %h, want %h", $time, what, got, want);
  endtask

  // Queue the ten beats of a presence reply for the given id.
  task automatic expect_reply(input logic [15:0] id);
    logic [7:0] reply[REPLY_BYTES];
    logic [7:0] sum;
    int k;
    sum = 8'h00;
    for (k = 0; k <= int'(IDX_SYNC_LAST); k++) reply[k] = cfg_sync;
    reply[IDX_LEN_HI]   = REPLY_LENGTH[15:8];
    reply[IDX_LEN_LO]   = REPLY_LENGTH[7:0];
    reply[IDX_ID_HI]    = id[15:8];
    reply[IDX_ID_LO]    = id[7:0];
    reply[IDX_PRESENCE] = PRESENCE;
    for (k = 0; k < int'(IDX_CHECKSUM); k++) sum ^= reply[k];
    reply[IDX_CHECKSUM] = sum;
    for (k = 0; k < int'(REPLY_BYTES); k++)
      reply_bytes_due.push_back({reply[k], k == int'(IDX_CHECKSUM)});
  endtask

  // Frame predictor: advance the parser by one accepted byte.
  task automatic predict_byte(input logic [7:0] b);
    if (parse_ph == PH_RESET) begin
      syncs_matched  = 3'd0;
      frame_pos      = 10'd0;
      frame_len      = 16'd0;
      frame_xor      = 8'd0;
      packet_id_seen = 16'd0;
      target_seen    = 16'd0;
      parse_ph       = PH_SYNC;
    end
    case (parse_ph)
      PH_SYNC: begin
        if (b == cfg_sync) begin
          frame_xor     ^= b;
          frame_pos     = frame_pos + 10'd1;
          syncs_matched = syncs_matched + 3'd1;
          if (syncs_matched >= SYNC_LEN) parse_ph = PH_LENHI;
        end else begin
          parse_ph = PH_RESET;
        end
      end
      PH_LENHI: begin
        frame_len = {8'h00, b};
        frame_xor ^= b;
        frame_pos = frame_pos + 10'd1;
        parse_ph  = PH_LENLO;
      end
      PH_LENLO: begin
        frame_len = {frame_len[7:0], b};
        if (frame_pos < frame_len) frame_xor ^= b;
        frame_pos = frame_pos + 10'd1;
        if (frame_len >= MIN_LENGTH && frame_len < BUF_LEN) parse_ph = PH_BODY;
        else parse_ph = PH_RESET;
      end
      PH_BODY: begin
        if (frame_pos < frame_len) frame_xor ^= b;
        if (frame_pos == SYNC_LEN + 2) packet_id_seen[15:8] = b;
        else if (frame_pos == SYNC_LEN + 3) packet_id_seen[7:0] = b;
        else if (frame_pos == SYNC_LEN + 4) target_seen[15:8] = b;
        else if (frame_pos == SYNC_LEN + 5) target_seen[7:0] = b;
        if (int'(frame_pos) + 1 >= int'(frame_len)) parse_ph = PH_CHECK;
        frame_pos = frame_pos + 10'd1;
      end
      PH_CHECK: begin
        parse_ph = PH_RESET;
        if (b == frame_xor && packet_id_seen == cfg_query && frame_len >= SYNC_LEN + 6) begin
          if (target_seen == cfg_first) expect_reply(cfg_first);
          else if (target_seen == cfg_second) expect_reply(cfg_second);
        end
      end
      default: parse_ph = PH_RESET;
    endcase
  endtask

  // Build one frame with the current sync value; a rejected length ends the
  // frame after the length field. keep, when nonzero, truncates the frame.
  task automatic queue_frame(input logic [15:0] len, input logic [15:0] pid,
                             input logic [15:0] tid, input bit bad_sum,
                             input int unsigned keep);
    logic [7:0] fb[$];
    logic [7:0] sum;
    int unsigned n;
    sum = 8'h00;
    for (int k = 0; k < SYNC_LEN; k++) fb.push_back(cfg_sync);
    fb.push_back(len[15:8]);
    fb.push_back(len[7:0]);
    if (len >= MIN_LENGTH && len < BUF_LEN) begin
      for (int k = SYNC_LEN + 2; k < len; k++) begin
        if (k == SYNC_LEN + 2) fb.push_back(pid[15:8]);
        else if (k == SYNC_LEN + 3) fb.push_back(pid[7:0]);
        else if (k == SYNC_LEN + 4) fb.push_back(tid[15:8]);
        else if (k == SYNC_LEN + 5) fb.push_back(tid[7:0]);
        else fb.push_back(8'($urandom_range(0, 255)));
      end
      foreach (fb[k]) sum ^= fb[k];
      if (bad_sum) sum ^= 8'($urandom_range(1, 255));
      fb.push_back(sum);
    end
    n = (keep != 0 && keep < fb.size()) ? keep : fb.size();
    for (int k = 0; k < n; k++) rx_pending.push_back(fb[k]);
    bytes_queued += n;
  endtask

  // Mostly well-formed queries, plus noise, rejected lengths and broken frames.
  task automatic queue_random_frame();
    int unsigned r;
    logic [15:0] len;
    logic [15:0] pid;
    logic [15:0] tid;
    int unsigned keep;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 5)) begin
        rx_pending.push_back(8'($urandom_range(0, 255)));
        bytes_queued++;
      end
    end
    r = $urandom_range(0, 99);
    if (r < 3) len = 16'($urandom_range(0, 7));
    else if (r < 6) len = 16'($urandom_range(BUF_LEN, 65535));
    else if (r < 8) len = 16'($urandom_range(25, 40));
    else if (r < 14) len = 16'($urandom_range(8, 9));
    else len = 16'($urandom_range(10, 24));
    pid = ($urandom_range(0, 3) != 0) ? cfg_query : 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    if (r < 40) tid = cfg_first;
    else if (r < 75) tid = cfg_second;
    else tid = 16'($urandom_range(0, 65535));
    keep = ($urandom_range(0, 19) == 0 && len < 32) ? $urandom_range(1, 12) : 0;
    queue_frame(len, pid, tid, $urandom_range(0, 9) == 0, keep);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_SYNC_VALUE: cfg_sync   = val[7:0];
      CFG_QUERY_ID:   cfg_query  = val;
      CFG_FIRST_ID:   cfg_first  = val;
      default:        cfg_second = val;
    endcase
  endtask

  // Write all four registers; the upper half of the sync write carries junk.
  task automatic write_config(input logic [7:0] sync_val, input logic [15:0] query_id,
                              input logic [15:0] first_id, input logic [15:0] second_id);
    write_reg(CFG_SYNC_VALUE, {8'($urandom_range(0, 255)), sync_val});
    write_reg(CFG_QUERY_ID, query_id);
    write_reg(CFG_FIRST_ID, first_id);
    write_reg(CFG_SECOND_ID, second_id);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every byte is taken and every reply beat has come out.
  task automatic settle_link();
    while (rx_pending.size() != 0 || rx_valid || reply_bytes_due.size() != 0)
      @(negedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Sender: hold a stalled beat, else take the next byte after its gap.
  always @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
      rx_wait = 0;
    end else if (!(rx_valid && rx_stall)) begin
      if (rx_valid) predict_byte(rx_byte);
      if (rx_wait != 0) begin
        rx_wait--;
        rx_valid <= 1'b0;
      end else if (rx_pending.size() != 0) begin
        rx_byte  <= rx_pending.pop_front();
        rx_valid <= 1'b1;
        rx_wait = draw_gap(rx_mode);
      end else begin
        rx_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each reply beat against the oldest prediction.
  always @(posedge clk) begin
    reply_beat_t want;
    if (rst) begin
      tx_stall <= 1'b0;
      tx_wait = 0;
    end else begin
      if (tx_valid && !tx_stall) begin
        if (reply_bytes_due.size() == 0) begin
          report_mismatch("reply beat with nothing expected", tx_byte, 8'h00);
        end else begin
          want = reply_bytes_due.pop_front();
          if (tx_byte !== want.data) report_mismatch("tx_byte", tx_byte, want.data);
          if (frame_end !== want.last)
            report_mismatch("frame_end", {7'd0, frame_end}, {7'd0, want.last});
        end
        tx_wait = draw_gap(tx_mode);
      end
      if (tx_wait != 0) begin
        tx_wait--;
        tx_stall <= 1'b1;
      end else begin
        tx_stall <= (hold_left != 0);
      end
    end
  end

  initial begin
    logic [15:0] first_id;
    int unsigned goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset register values: sync 0, both ids 0, so the first id answers.
    @(negedge clk);
    rx_mode = 1;
    tx_mode = 1;
    queue_frame(16'd10, 16'd161, 16'd0, 1'b0, 0);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h80);
    queue_frame(16'd10, 16'd161, 16'd0, 1'b0, 0);
    settle_link();

    // Ordinary ids: both targets, misses, bad checksum, broken hunt, lengths.
    write_config(8'h55, 16'h1234, 16'hABCD, 16'h0102);
    @(negedge clk);
    rx_mode = 2;
    tx_mode = 0;
    queue_frame(16'd10, 16'h1234, 16'hABCD, 1'b0, 0);
    queue_frame(16'd14, 16'h1234, 16'h0102, 1'b0, 0);
    queue_frame(16'd10, 16'h1234, 16'h0BAD, 1'b0, 0);
    queue_frame(16'd10, 16'h1234, 16'hABCD, 1'b1, 0);
    queue_frame(16'd10, 16'h4321, 16'hABCD, 1'b0, 0);
    rx_pending.push_back(8'h55);
    rx_pending.push_back(8'h55);
    rx_pending.push_back(8'h00);
    queue_frame(16'd10, 16'h1234, 16'hABCD, 1'b0, 0);
    queue_frame(16'd7, 16'h1234, 16'hABCD, 1'b0, 0);
    queue_frame(16'd512, 16'h1234, 16'hABCD, 1'b0, 0);
    queue_frame(16'd0, 16'h1234, 16'hABCD, 1'b0, 0);
    queue_frame(16'd8, 16'h1234, 16'hABCD, 1'b0, 0);
    settle_link();

    // All-ones extremes; frames too short to hold a target must stay silent.
    write_config(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    @(negedge clk);
    rx_mode = 0;
    tx_mode = 2;
    queue_frame(16'd10, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    queue_frame(16'd12, 16'hFFFF, 16'h0000, 1'b0, 0);
    queue_frame(16'd8, 16'hFFFF, 16'h0000, 1'b0, 0);
    queue_frame(16'd9, 16'hFFFF, 16'h0000, 1'b0, 0);
    queue_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0);
    queue_frame(16'd10, 16'h0000, 16'hFFFF, 1'b0, 0);
    settle_link();

    // Zero query id and both sensor ids equal.
    write_config(8'h00, 16'h0000, 16'h7777, 16'h7777);
    @(negedge clk);
    rx_mode = 1;
    tx_mode = 1;
    queue_frame(16'd10, 16'h0000, 16'h7777, 1'b0, 0);
    queue_frame(16'd11, 16'h0000, 16'h7776, 1'b0, 0);
    settle_link();

    // Random settings, taking the three mixes of idling on both sides in turn.
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      first_id = pick_value(16'hFFFF);
      write_config(pick_value(16'h00FF), pick_value(16'hFFFF), first_id,
                   ($urandom_range(0, 9) == 0) ? first_id : pick_value(16'hFFFF));
      @(negedge clk);
      rx_mode = ph_i % 3;
      tx_mode = (ph_i + 2) % 3;
      goal = bytes_queued + 12;
      while (bytes_queued < goal) queue_random_frame();
      settle_link();
    end

    // Receiver holds off while queries keep arriving back to back.
    write_config(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    @(negedge clk);
    rx_mode = 0;
    tx_mode = 0;
    repeat (4) queue_frame(16'd10, cfg_query, cfg_first, 1'b0, 0);
    settle_link();

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
